// ===== rtl/dsp_pkg.sv =====
package dsp_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int MAX_EDGES_DEF = 64;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_CLR  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         from_node;
    logic [3:0]         to_node;
    logic signed [15:0] weight;
    logic [3:0]         source_node;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         node;
    logic signed [23:0] distance;
    logic               reachable;
    logic [1:0]         status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [3:0]         from_node;
    logic [3:0]         to_node;
    logic signed [15:0] weight;
  } edge_t;

  function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
                                                 input logic signed [15:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    if (s > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (s < -25'sd8388608) begin
      return 24'sh800000;
    end else begin
      return 24'(s);
    end
  endfunction

endpackage

// ===== rtl/dag_shortest_path_unit.sv =====
// Single-source shortest paths over a weighted directed graph.
// Command channel: cmd is taken at a clock edge with start high and busy low.
//   op add appends an edge, op clear empties the edge table, op run computes
//   distances from cmd.source_node; op 3 is dropped without a result.
// Result channel: result_valid strobes for one cycle per result; the receiver
//   must take it then, there is no back pressure.
// Add, clear and any rejected command answer in the cycle after acceptance with
//   a single status result and never raise busy.
// A run raises busy, builds a depth-first post-order, relaxes edges in
//   reverse post-order, then emits node_count results, one per cycle, node 0
//   first, last set on the final one. Every edge scan reads the edge memory
//   one stored edge at a time, with a scan and a check state per edge.
// Config: cfg_data writes node_count when cfg_valid and cfg_ready are high;
//   cfg_ready is low while busy. Zero is raised to one, large values clamp.
// Reset (rst, synchronous): edge table empty, node_count = min(MAX_NODES, 16), no result.
module dag_shortest_path_unit
  import dsp_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  output logic       result_valid,
  output result_t    result
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int ET_W  = $clog2(MAX_EDGES + 1);
  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NODE_RST = (MAX_NODES < 16) ? MAX_NODES : 16;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_DSCAN, S_DCHK, S_RINIT, S_RNEXT, S_RLOAD, S_RSCAN,
    S_RCHK, S_OUT
  } state_t;

  state_t state;

  logic [CNT_W-1:0] node_count;
  logic [ET_W-1:0]  edge_total;
  logic [CNT_W-1:0] root;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] idx;
  logic [NW-1:0]    depth;
  logic [NW-1:0]    cur_u;
  logic [ET_W-1:0]  cur_e;
  logic [NW-1:0]    src;
  logic [NW-1:0]    out_i;
  logic signed [23:0] du;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] dvalid;
  logic signed [23:0] node_dist [MAX_NODES];
  logic [NW-1:0]      topo  [MAX_NODES];
  logic [NW-1:0]      stk_u [MAX_NODES];
  logic [ET_W-1:0]    stk_e [MAX_NODES];

  edge_t edge_q;
  edge_t edge_w;
  logic  edge_we;
  logic  accept;
  logic  add_bad, add_full, src_bad;
  logic  e_from_ok, e_to_ok;
  logic [NW-1:0]    e_to;
  logic [NW-1:0]    rd_node;
  logic signed [23:0] rd_dist;
  logic               rd_valid;
  logic signed [23:0] sum;
  logic [NW-1:0]    topo_u;
  logic [4:0]       cfg_clamped;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  assign add_bad  = (CMP_W'(cmd.from_node) >= CMP_W'(node_count)) ||
                    (CMP_W'(cmd.to_node) >= CMP_W'(node_count));
  assign add_full = (edge_total == ET_W'(MAX_EDGES));
  assign src_bad  = (CMP_W'(cmd.source_node) >= CMP_W'(node_count));
  assign edge_we  = accept && (cmd.op == OP_ADD) && !add_bad && !add_full;
  assign edge_w   = '{from_node: cmd.from_node, to_node: cmd.to_node,
                      weight: cmd.weight};

  dsp_edge_mem #(.DEPTH(MAX_EDGES), .AW(EA_W)) u_edges (
    .clk   (clk),
    .we    (edge_we),
    .waddr (EA_W'(edge_total)),
    .wdata (edge_w),
    .raddr (EA_W'(cur_e)),
    .rdata (edge_q)
  );

  assign e_to      = NW'(edge_q.to_node);
  assign e_from_ok = (CMP_W'(edge_q.from_node) == CMP_W'(cur_u));
  assign e_to_ok   = (CMP_W'(edge_q.to_node) < CMP_W'(node_count));
  assign topo_u    = topo[NW'(idx - CNT_W'(1))];

  always_comb begin
    unique case (state)
      S_RCHK:  rd_node = e_to;
      S_OUT:   rd_node = out_i;
      default: rd_node = cur_u;
    endcase
  end

  assign rd_dist  = node_dist[rd_node];
  assign rd_valid = dvalid[rd_node];
  assign sum      = sat_add(du, edge_q.weight);

  always_comb begin
    if (cfg_data == 5'd0) begin
      cfg_clamped = 5'd1;
    end else if (CMP_W'(cfg_data) > CMP_W'(MAX_NODES)) begin
      cfg_clamped = 5'(MAX_NODES);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    result_t result_next;
    if (rst) begin
      state        <= S_IDLE;
      node_count   <= CNT_W'(NODE_RST);
      edge_total   <= '0;
      result_valid <= 1'b0;
      result       <= '0;
      visited      <= '0;
      dvalid       <= '0;
    end else begin
      result_next = '0;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        node_count <= CNT_W'(cfg_clamped);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result_next.last = 1'b1;
            case (cmd.op)
              OP_ADD: begin
                result_valid <= 1'b1;
                if (add_bad) begin
                  result_next.status = ST_RANGE;
                end else if (add_full) begin
                  result_next.status = ST_FULL;
                end else begin
                  edge_total <= edge_total + ET_W'(1);
                end
              end
              OP_CLR: begin
                result_valid <= 1'b1;
                edge_total   <= '0;
              end
              OP_RUN: begin
                if (src_bad) begin
                  result_valid <= 1'b1;
                  result_next.status = ST_RANGE;
                end else begin
                  src     <= NW'(cmd.source_node);
                  visited <= '0;
                  root    <= '0;
                  cnt     <= '0;
                  state   <= S_ROOT;
                end
              end
              default: ;
            endcase
          end
        end
        S_ROOT: begin
          if (root == node_count) begin
            state <= S_RINIT;
          end else if (visited[NW'(root)]) begin
            root <= root + CNT_W'(1);
          end else begin
            visited[NW'(root)] <= 1'b1;
            cur_u <= NW'(root);
            cur_e <= '0;
            depth <= '0;
            state <= S_DSCAN;
          end
        end
        S_DSCAN: begin
          if (cur_e >= edge_total) begin
            // node finished: record in post-order and pop
            topo[NW'(cnt)] <= cur_u;
            cnt <= cnt + CNT_W'(1);
            if (depth == '0) begin
              root  <= root + CNT_W'(1);
              state <= S_ROOT;
            end else begin
              cur_u <= stk_u[depth - NW'(1)];
              cur_e <= stk_e[depth - NW'(1)];
              depth <= depth - NW'(1);
            end
          end else begin
            state <= S_DCHK;
          end
        end
        S_DCHK: begin
          if (e_from_ok && e_to_ok && !visited[e_to]) begin
            stk_u[depth] <= cur_u;
            stk_e[depth] <= cur_e + ET_W'(1);
            depth <= depth + NW'(1);
            visited[e_to] <= 1'b1;
            cur_u <= e_to;
            cur_e <= '0;
          end else begin
            cur_e <= cur_e + ET_W'(1);
          end
          state <= S_DSCAN;
        end
        S_RINIT: begin
          dvalid         <= MAX_NODES'(1) << src;
          node_dist[src] <= '0;
          idx            <= cnt;
          state          <= S_RNEXT;
        end
        S_RNEXT: begin
          if (idx == '0) begin
            out_i <= '0;
            state <= S_OUT;
          end else begin
            idx <= idx - CNT_W'(1);
            if (dvalid[topo_u]) begin
              cur_u <= topo_u;
              state <= S_RLOAD;
            end
          end
        end
        S_RLOAD: begin
          du    <= rd_dist;
          cur_e <= '0;
          state <= S_RSCAN;
        end
        S_RSCAN: begin
          if (cur_e >= edge_total) begin
            state <= S_RNEXT;
          end else begin
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          if (e_from_ok && e_to_ok && (!rd_valid || (sum < rd_dist))) begin
            node_dist[e_to] <= sum;
            dvalid[e_to]    <= 1'b1;
            // self loop lowers the distance used by the rest of this node
            if (e_to == cur_u) begin
              du <= sum;
            end
          end
          cur_e <= cur_e + ET_W'(1);
          state <= S_RSCAN;
        end
        S_OUT: begin
          result_valid <= 1'b1;
          result_next.node      = 4'(out_i);
          result_next.reachable = rd_valid;
          result_next.distance  = rd_valid ? rd_dist : 24'sd0;
          result_next.status    = ST_OK;
          if ((CNT_W'(out_i) + CNT_W'(1)) == node_count) begin
            result_next.last = 1'b1;
            state <= S_IDLE;
          end else begin
            out_i <= out_i + NW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
      result <= result_next;
    end
  end

endmodule

// ===== rtl/dsp_edge_mem.sv =====
module dsp_edge_mem
  import dsp_pkg::*;
#(
  parameter int DEPTH = MAX_EDGES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  edge_t         wdata,
  input  logic [AW-1:0] raddr,
  output edge_t         rdata
);

  edge_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dsp_checker.sv =====
module dsp_checker
  import dsp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input cmd_t       cmd,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [4:0] cfg_data,
  input logic       result_valid,
  input result_t    result
);

  a_short_ops: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.op == OP_ADD || cmd.op == OP_CLR))
      |=> (result_valid && result.last))
    else $error("add/clear item gave no single result");

  a_drop_op: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.op == OP_NONE) |=> !result_valid)
    else $error("unused op produced a result");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK)
      |-> (result.node == 4'd0 && result.distance == 24'sd0 && !result.reachable
           && result.last))
    else $error("status result carries payload");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.reachable) |-> (result.distance == 24'sd0))
    else $error("unreachable node with nonzero distance");

endmodule

bind dag_shortest_path_unit dsp_checker u_dsp_checker (.*);
